// File: rtl/core/apas_pkg.sv
`default_nettype none

package apas_pkg;

  localparam int NUM_ARMS_DEF = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PROB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 2'd2;

  localparam logic ACT_SELECT = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic [15:0] PROB_RESET  = 16'd13107;
  localparam logic [15:0] LR_RESET    = 16'd6554;
  localparam logic [15:0] FLOOR_RESET = 16'd3277;

  localparam logic [16:0] Q16_ONE         = 17'h10000;
  localparam logic [16:0] NO_ATTEMPT_RATE = 17'd32768;
  localparam logic [16:0] MEAN_SCALE      = 17'd25600;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

  localparam int DIV_DVD_W = 48;
  localparam int DIV_DSR_W = 32;
  localparam int SCORE_W   = 34;

  typedef struct packed {
    logic        action;
    logic [2:0]  arm;
    logic        improved;
    logic [15:0] improvement;
    logic [15:0] random_draw;
  } cmd_t;

  typedef struct packed {
    logic [2:0] chosen_arm;
    logic       is_selection;
  } rsp_t;

  typedef struct packed {
    logic [31:0] attempts;
    logic [31:0] successes;
    logic [15:0] mean;
    logic [15:0] prob;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: rtl/core/apas_ram.sv
`default_nettype none

module apas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/apas_div.sv
`default_nettype none

// restoring divider, one quotient bit a cycle
module apas_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [apas_pkg::DIV_DVD_W-1:0]  dividend,
  input  wire logic [apas_pkg::DIV_DSR_W-1:0]  divisor,
  output      logic                            done,
  output      logic [apas_pkg::DIV_DVD_W-1:0]  quotient
);

  localparam int CW = $clog2(apas_pkg::DIV_DVD_W + 1);

  logic [CW-1:0]                    cnt;
  logic [apas_pkg::DIV_DSR_W:0]     rem;
  logic [apas_pkg::DIV_DSR_W-1:0]   dsr;
  logic [apas_pkg::DIV_DVD_W-1:0]   dvd;
  logic [apas_pkg::DIV_DSR_W:0]     rem_sh;
  logic                             fits;

  assign rem_sh   = {rem[apas_pkg::DIV_DSR_W-1:0], dvd[apas_pkg::DIV_DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(apas_pkg::DIV_DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      rem <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
      dvd <= {dvd[apas_pkg::DIV_DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/adaptive_pursuit_arm_selector.sv
`default_nettype none

// Adaptive pursuit arm selector.
// Request channel cmd (cmd_valid/cmd_stall) carries either a select
// (action 0: roulette over the arm probabilities using random_draw) or an
// update (action 1: record the outcome for arm, then re-score every arm and
// pursue the best ones). Every request gives one response on rsp
// (rsp_valid/rsp_stall): the chosen arm, or the echoed arm for an update.
// Requests are handled one at a time; cmd_stall is high while one is in work.
// Arm state lives in a one-port-read RAM, scores in a second RAM.
// Select: a sum walk over all arms, then a search walk that stops at the
// chosen arm. Update: record the outcome, dividing for the new mean on an
// improvement (48-bit bit-serial divider); then per arm a score, the rate
// divided when the arm has attempts, and a pursuit step; then the response.
// The response sits in an output register; the next request is taken while
// it waits, and a finished request holds until the register is free.
// Reset (rst, synchronous) clears counts and means, sets every probability
// to 13107 and restores the registers; no clearing pass is needed.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle; the block itself does not enforce it.
module adaptive_pursuit_arm_selector #(
  parameter int NUM_ARMS = apas_pkg::NUM_ARMS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output      logic                            cmd_stall,
  input  wire apas_pkg::cmd_t                  cmd,
  output      logic                            rsp_valid,
  input  wire logic                            rsp_stall,
  output      apas_pkg::rsp_t                  rsp,
  input  wire logic                            cfg_we,
  input  wire logic [apas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [apas_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW    = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam int SUM_W = 16 + AW;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_T_RD  = 5'd1;
  localparam logic [4:0] ST_T_ACC = 5'd2;
  localparam logic [4:0] ST_T_MUL = 5'd3;
  localparam logic [4:0] ST_C_RD  = 5'd4;
  localparam logic [4:0] ST_C_CHK = 5'd5;
  localparam logic [4:0] ST_U_RD  = 5'd6;
  localparam logic [4:0] ST_U_CAL = 5'd7;
  localparam logic [4:0] ST_U_MUL = 5'd8;
  localparam logic [4:0] ST_U_DIV = 5'd9;
  localparam logic [4:0] ST_U_WR  = 5'd10;
  localparam logic [4:0] ST_S_RD  = 5'd11;
  localparam logic [4:0] ST_S_DAT = 5'd12;
  localparam logic [4:0] ST_S_DIV = 5'd13;
  localparam logic [4:0] ST_S_MUL = 5'd14;
  localparam logic [4:0] ST_S_WR  = 5'd15;
  localparam logic [4:0] ST_P_RD  = 5'd16;
  localparam logic [4:0] ST_P_DAT = 5'd17;
  localparam logic [4:0] ST_P_MUL = 5'd18;
  localparam logic [4:0] ST_P_WR  = 5'd19;
  localparam logic [4:0] ST_DONE  = 5'd20;

  logic [4:0]                        state;
  apas_pkg::cmd_t                    req;
  logic [AW-1:0]                     idx;
  logic [AW-1:0]                     arm_idx;
  logic                              idx_last;
  logic [NUM_ARMS-1:0]               valid;
  logic                              rd_valid;
  apas_pkg::entry_t                  ram_q;
  apas_pkg::entry_t                  eff;
  apas_pkg::entry_t                  ent;
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [AW-1:0]                     ram_raddr;
  logic                              sc_we;
  logic [apas_pkg::SCORE_W-1:0]      score;
  logic [apas_pkg::SCORE_W-1:0]      score_q;
  logic [apas_pkg::SCORE_W-1:0]      best;
  logic [SUM_W-1:0]                  total;
  logic [SUM_W-1:0]                  target;
  logic [SUM_W-1:0]                  cum;
  logic [SUM_W-1:0]                  cum_next;
  logic [16+SUM_W-1:0]               tprod;
  logic [apas_pkg::DIV_DVD_W-1:0]    mprod;
  logic [16:0]                       rate;
  logic [32:0]                       step_prod;
  logic                              up;
  logic [15:0]                       lr;
  logic [15:0]                       floor_p;
  logic [2:0]                        res_arm;
  logic                              arm_ok;
  logic [31:0]                       att_inc;
  logic [31:0]                       suc_inc;
  logic [16:0]                       p17;
  logic [16:0]                       tgt;
  logic [16:0]                       diff;
  logic [16:0]                       step;
  logic                              div_start;
  logic                              div_done;
  logic [apas_pkg::DIV_DVD_W-1:0]    div_dvd;
  logic [apas_pkg::DIV_DSR_W-1:0]    div_dsr;
  logic [apas_pkg::DIV_DVD_W-1:0]    div_q;

  assign cmd_stall = (state != ST_IDLE);
  assign arm_idx   = AW'(req.arm);
  assign idx_last  = (idx == AW'(NUM_ARMS - 1));
  assign arm_ok    = ({29'd0, cmd.arm} < 32'(NUM_ARMS));

  assign eff = rd_valid ? ram_q : '{attempts: '0, successes: '0, mean: '0,
                                    prob: apas_pkg::PROB_RESET};

  assign ram_raddr = (state == ST_U_RD) ? arm_idx : idx;
  assign ram_we    = (state == ST_U_WR) || (state == ST_P_WR);
  assign ram_waddr = (state == ST_U_WR) ? arm_idx : idx;
  assign sc_we     = (state == ST_S_WR);

  assign att_inc  = (eff.attempts == apas_pkg::COUNT_MAX) ? eff.attempts
                                                          : eff.attempts + 32'd1;
  assign suc_inc  = (eff.successes == apas_pkg::COUNT_MAX) ? eff.successes
                                                           : eff.successes + 32'd1;
  assign tprod    = req.random_draw * total;
  assign cum_next = cum + SUM_W'(eff.prob);

  assign p17  = {1'b0, eff.prob};
  assign tgt  = (score_q == best) ? apas_pkg::Q16_ONE : {1'b0, floor_p};
  assign diff = (tgt >= p17) ? (tgt - p17) : (p17 - tgt);
  assign step = step_prod[32:16];

  assign div_start = (state == ST_U_MUL) ||
                     ((state == ST_S_DAT) && (eff.attempts != '0));
  assign div_dvd   = (state == ST_U_MUL) ? (mprod + apas_pkg::DIV_DVD_W'(req.improvement))
                                         : {eff.successes, 16'd0};
  assign div_dsr   = (state == ST_U_MUL) ? ent.successes : eff.attempts;

  apas_ram #(
    .WIDTH (apas_pkg::ENTRY_W),
    .DEPTH (NUM_ARMS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ent),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  apas_ram #(
    .WIDTH (apas_pkg::SCORE_W),
    .DEPTH (NUM_ARMS)
  ) u_score_ram (
    .clk   (clk),
    .we    (sc_we),
    .waddr (idx),
    .wdata (score),
    .raddr (idx),
    .rdata (score_q)
  );

  apas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lr      <= apas_pkg::LR_RESET;
      floor_p <= apas_pkg::FLOOR_RESET;
    end else if (cfg_we) begin
      priority if (cfg_index == apas_pkg::CFG_LEARN) begin
        lr <= cfg_data;
      end else if (cfg_index == apas_pkg::CFG_FLOOR) begin
        floor_p <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[ram_waddr] <= 1'b1;
    end
    rd_valid <= valid[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            req   <= cmd;
            idx   <= '0;
            total <= '0;
            res_arm <= cmd.arm;
            if (cmd.action == apas_pkg::ACT_SELECT) begin
              state <= ST_T_RD;
            end else if (arm_ok) begin
              state <= ST_U_RD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_T_RD: state <= ST_T_ACC;
        ST_T_ACC: begin
          total <= total + SUM_W'(eff.prob);
          if (idx_last) begin
            idx   <= '0;
            state <= ST_T_MUL;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_T_RD;
          end
        end
        ST_T_MUL: begin
          target <= tprod[16+SUM_W-1:16];
          cum    <= '0;
          if (total == '0) begin
            res_arm <= 3'd0;
            state   <= ST_DONE;
          end else begin
            state <= ST_C_RD;
          end
        end
        ST_C_RD: state <= ST_C_CHK;
        ST_C_CHK: begin
          cum <= cum_next;
          if ((target < cum_next) || idx_last) begin
            res_arm <= 3'(idx);
            state   <= ST_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_C_RD;
          end
        end
        ST_U_RD: state <= ST_U_CAL;
        ST_U_CAL: begin
          ent <= '{attempts:  att_inc,
                   successes: req.improved ? suc_inc : eff.successes,
                   mean:      eff.mean,
                   prob:      eff.prob};
          if (req.improved) begin
            mprod <= apas_pkg::DIV_DVD_W'(eff.mean) *
                     apas_pkg::DIV_DVD_W'(suc_inc - 32'd1);
            state <= ST_U_MUL;
          end else begin
            state <= ST_U_WR;
          end
        end
        ST_U_MUL: state <= ST_U_DIV;
        ST_U_DIV: begin
          if (div_done) begin
            ent.mean <= div_q[15:0];
            state    <= ST_U_WR;
          end
        end
        ST_U_WR: begin
          idx   <= '0;
          best  <= '0;
          state <= ST_S_RD;
        end
        ST_S_RD: state <= ST_S_DAT;
        ST_S_DAT: begin
          ent <= eff;
          if (eff.attempts == '0) begin
            rate  <= apas_pkg::NO_ATTEMPT_RATE;
            state <= ST_S_MUL;
          end else begin
            state <= ST_S_DIV;
          end
        end
        ST_S_DIV: begin
          if (div_done) begin
            rate  <= div_q[16:0];
            state <= ST_S_MUL;
          end
        end
        ST_S_MUL: begin
          score <= apas_pkg::SCORE_W'(rate) *
                   apas_pkg::SCORE_W'(apas_pkg::MEAN_SCALE + 17'(ent.mean));
          state <= ST_S_WR;
        end
        ST_S_WR: begin
          if (score > best) begin
            best <= score;
          end
          if (idx_last) begin
            idx   <= '0;
            state <= ST_P_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_S_RD;
          end
        end
        ST_P_RD: state <= ST_P_DAT;
        ST_P_DAT: begin
          ent       <= eff;
          up        <= (tgt >= p17);
          step_prod <= 33'(lr) * 33'(diff);
          state     <= ST_P_MUL;
        end
        ST_P_MUL: begin
          ent.prob <= up ? (ent.prob + step[15:0]) : (ent.prob - step[15:0]);
          state    <= ST_P_WR;
        end
        ST_P_WR: begin
          if (idx_last) begin
            state <= ST_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_P_RD;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= '{chosen_arm:   res_arm,
                           is_selection: (req.action == apas_pkg::ACT_SELECT)};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/apas_chk.sv
`default_nettype none

module apas_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire apas_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && !cmd_stall)
    else $error("not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("request taken while busy");

endmodule

bind adaptive_pursuit_arm_selector apas_chk u_apas_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// File: sim/tb_adaptive_pursuit_arm_selector.sv
`timescale 1ns / 100ps

module tb_adaptive_pursuit_arm_selector;
  import apas_pkg::*;

  localparam int ARMS = NUM_ARMS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 600;

  class arm_pursuit_scoreboard;
    logic [31:0] attempts[ARMS];
    logic [31:0] successes[ARMS];
    logic [15:0] mean[ARMS];
    logic [15:0] prob[ARMS];
    logic [15:0] learn;
    logic [15:0] floor_p;
    rsp_t        pending_rsp[$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < ARMS; i++) begin
        attempts[i] = '0;
        successes[i] = '0;
        mean[i] = '0;
        prob[i] = PROB_RESET;
      end
      learn = LR_RESET;
      floor_p = FLOOR_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_LEARN) learn = val;
      else if (idx == CFG_FLOOR) floor_p = val;
    endfunction

    function logic [2:0] roulette(logic [15:0] draw);
      logic [63:0] total;
      logic [63:0] target;
      logic [63:0] cum;
      total = 0;
      cum = 0;
      for (int i = 0; i < ARMS; i++) total += prob[i];
      if (total == 0) return 3'd0;
      target = (64'(draw) * total) >> 16;
      for (int i = 0; i < ARMS; i++) begin
        cum += prob[i];
        if (target < cum) return i[2:0];
      end
      return 3'(ARMS - 1);
    endfunction

    function logic [15:0] pursue(logic [15:0] p, logic [16:0] tgt);
      logic [63:0] step;
      if (tgt >= 17'(p)) begin
        step = (64'(learn) * 64'(tgt - 17'(p))) >> 16;
        return 16'(64'(p) + step);
      end
      step = (64'(learn) * 64'(17'(p) - tgt)) >> 16;
      return 16'(64'(p) - step);
    endfunction

    function void record_and_pursue(cmd_t c);
      logic [63:0] s;
      logic [63:0] acc;
      logic [63:0] rate;
      logic [63:0] score[ARMS];
      logic [63:0] best;
      int a;
      a = c.arm;
      if (attempts[a] != COUNT_MAX) attempts[a]++;
      if (c.improved) begin
        if (successes[a] != COUNT_MAX) successes[a]++;
        s = successes[a];
        acc = 64'(mean[a]) * (s - 1) + 64'(c.improvement);
        mean[a] = 16'(acc / s);
      end
      best = 0;
      for (int i = 0; i < ARMS; i++) begin
        if (attempts[i] == 0) rate = 64'(NO_ATTEMPT_RATE);
        else rate = (64'(successes[i]) << 16) / 64'(attempts[i]);
        score[i] = rate * (64'(MEAN_SCALE) + 64'(mean[i]));
        if (score[i] > best) best = score[i];
      end
      for (int i = 0; i < ARMS; i++)
        prob[i] = pursue(prob[i], (score[i] == best) ? Q16_ONE : {1'b0, floor_p});
    endfunction

    function void note(cmd_t c);
      rsp_t r;
      if (c.action == ACT_SELECT) begin
        r.chosen_arm = roulette(c.random_draw);
        r.is_selection = 1'b1;
      end else begin
        if (int'(c.arm) < ARMS) record_and_pursue(c);
        r.chosen_arm = c.arm;
        r.is_selection = 1'b0;
      end
      pending_rsp = {pending_rsp, r};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(rsp_t got);
      rsp_t want;
      checked++;
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected response arm %0d sel %0b",
                         got.chosen_arm, got.is_selection));
        return;
      end
      want = pending_rsp.pop_front();
      if (got.chosen_arm !== want.chosen_arm)
        report($sformatf("response %0d chosen_arm %0d, want %0d",
                         checked, got.chosen_arm, want.chosen_arm));
      if (got.is_selection !== want.is_selection)
        report($sformatf("response %0d is_selection %0b, want %0b",
                         checked, got.is_selection, want.is_selection));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  arm_pursuit_scoreboard sb = new();
  bit calm = 1'b0;
  int idle_cycles = 0;
  int n_select = 0;
  int n_update = 0;
  int n_settings = 0;

  always #6 clk = ~clk;

  adaptive_pursuit_arm_selector i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((rsp_valid && !rsp_stall) || (cmd_valid && !cmd_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (rsp_valid && !rsp_stall) sb.check(rsp);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send(cmd_t c);
    while (!calm && $urandom_range(99) < 11) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    sb.note(c);
    if (c.action == ACT_SELECT) n_select++;
    else n_update++;
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(idx, val);
    @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(logic act, logic [2:0] a, logic imp,
                                    logic [15:0] amount, logic [15:0] draw);
    cmd_t c;
    c.action = act;
    c.arm = a;
    c.improved = imp;
    c.improvement = amount;
    c.random_draw = draw;
    return c;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int n);
    cmd_t c;
    for (int k = 0; k < n; k++) begin
      c = cmd_t'($urandom);
      c.action = ($urandom_range(1) == 0) ? ACT_SELECT : ACT_UPDATE;
      c.improvement = pick16();
      c.random_draw = pick16();
      if ($urandom_range(3) == 0) c.arm = 3'($urandom_range(1));
      send(c);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: draw extremes, every arm, improvement extremes
    send(make_cmd(ACT_SELECT, 3'd0, 1'b0, 16'h0000, 16'h0000));
    send(make_cmd(ACT_SELECT, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF));
    for (int a = 0; a < ARMS; a++)
      send(make_cmd(ACT_UPDATE, 3'(a), a[0], (a < 4) ? 16'hFFFF : 16'h0000, 16'h8000));
    send(make_cmd(ACT_UPDATE, 3'd2, 1'b1, 16'hFFFF, 16'h0000));
    send(make_cmd(ACT_UPDATE, 3'd2, 1'b1, 16'h0001, 16'hFFFF));
    send(make_cmd(ACT_SELECT, 3'd0, 1'b0, 16'h0000, 16'h0000));
    send(make_cmd(ACT_SELECT, 3'd0, 1'b0, 16'h0000, 16'hFFFF));
    send(make_cmd(ACT_SELECT, 3'd0, 1'b0, 16'h0000, 16'h7FFF));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_LEARN, 16'hFFFF); write_reg(CFG_FLOOR, 16'h0000); end
        1: begin write_reg(CFG_LEARN, 16'h0000); write_reg(CFG_FLOOR, 16'hFFFF); end
        2: begin write_reg(CFG_INIT_PROB, 16'h0000); write_reg(2'd3, 16'hFFFF); end
        3: begin write_reg(CFG_LEARN, pick16()); write_reg(CFG_FLOOR, pick16()); end
        4: begin write_reg(CFG_INIT_PROB, 16'hFFFF); write_reg(CFG_LEARN, LR_RESET); end
        default: begin write_reg(CFG_LEARN, 16'h8000); write_reg(CFG_FLOOR, FLOOR_RESET); end
      endcase
      n_settings++;
      calm = (phase == 3);
      random_run(100);
      // let every outstanding request come back before carrying on
      cmd_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clk);
      random_run(105);
      drain();
    end

    calm = 1'b0;
    drain();
    $display("covered %0d selects and %0d updates over %0d register settings",
             n_select, n_update, n_settings);
    $display("%0d responses checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
